// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property, disabled while the active-low reset is low.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication form: antecedent on one edge, consequent on the next.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  `ASSERT_PROP(lbl, clk, rst_n, (ante) |=> (cons), msg)
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/hsm_pkg.sv =====
// Shared types and constants of the handle slot map.
package hsm_pkg;

  localparam int NUM_HANDLES_DEF = 64;
  localparam int ROW_W_MAX       = 64;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_DEL = 2'd1,
    CMD_MOD = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EXEC = 3'b100
  } state_t;

endpackage

// ===== rtl/hsm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/handle_slot_map.sv =====
// Top level of the handle slot map: handle table, dense store bookkeeping.
// Usage
//   Input beat: in_cmd (add, delete, modify lookup) and in_handle_in.
//   Output beat: out_status, out_handle_out, out_position, out_move_source,
//   out_live_count. One output beat for every input beat, in order.
//   Add grants the lowest free handle at position live_count; delete reports
//   the move of the last dense position (out_move_source) into the freed
//   one (out_position); modify returns the handle's position.
// Timing
//   An input beat is taken only while the block is idle (in_stall low).
//   Accept edge -> RAM read cycle -> execute/write-back cycle; the result is
//   loaded into the output register in the execute cycle, after which the
//   block is idle again; a new beat is taken only once the last is through.
//   The read cycle exists because the state RAMs register their read data.
//   If out_stall holds a pending result, the execute cycle waits, so the
//   block never overwrites an untaken result and no RAM write is repeated.
// Reset
//   rst_n (synchronous, active low) clears the per-row valid and full bits of the
//   live bitmap, so every handle reads free at once; live_count returns to zero.
//   The handle->position and position->handle RAMs need no reset: only live entries are read.
module handle_slot_map #(
  parameter int NUM_HANDLES = hsm_pkg::NUM_HANDLES_DEF,
  parameter int HW          = $clog2(NUM_HANDLES),
  parameter int CW          = $clog2(NUM_HANDLES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  // input channel
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_cmd,
  input  logic [HW-1:0] in_handle_in,
  // result channel
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    out_status,
  output logic [HW-1:0] out_handle_out,
  output logic [HW-1:0] out_position,
  output logic [HW-1:0] out_move_source,
  output logic [CW-1:0] out_live_count
);

  // live bitmap geometry: rows of ROW_W bits, handle = {row, bit}
  localparam int ROW_W = (NUM_HANDLES >= hsm_pkg::ROW_W_MAX) ? hsm_pkg::ROW_W_MAX
                                                             : 2 ** $clog2(NUM_HANDLES);
  localparam int ROWS  = (NUM_HANDLES + ROW_W - 1) / ROW_W;
  localparam int BW    = $clog2(ROW_W);
  localparam int RIW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  hsm_pkg::state_t state_r, state_nxt;

  logic [1:0]      cmd_r;
  logic [HW-1:0]   hin_r;
  logic [CW-1:0]   count_r, count_nxt;
  logic [RIW-1:0]  add_row_r;
  logic [ROWS-1:0] row_valid_r;
  logic [ROWS-1:0] row_full_r;

  logic            out_valid_r;
  logic [1:0]      out_status_r;
  logic [HW-1:0]   out_handle_r;
  logic [HW-1:0]   out_pos_r;
  logic [HW-1:0]   out_src_r;

  // RAM ports
  logic             live_wr_en, pos_wr_en, hnd_wr_en, rd_en;
  logic [RIW-1:0]   live_wr_addr, live_rd_addr;
  logic [ROW_W-1:0] live_wr_data, live_rd;
  logic [HW-1:0]    pos_wr_addr, pos_wr_data, pos_rd;
  logic [HW-1:0]    hnd_wr_addr, hnd_wr_data, hnd_rd, hnd_rd_addr;

  // execute-cycle signals
  logic             in_fire, out_free, exec_fire;
  logic [RIW-1:0]   free_row, hin_row, cur_row;
  logic [BW-1:0]    hin_bit, fz;
  logic             fz_found, hin_in_range, hin_live;
  logic [ROW_W-1:0] row_mask, live_eff, occ;
  logic [HW-1:0]    h_new, cnt_pos;
  hsm_pkg::status_t res_status;
  logic [HW-1:0]    res_handle, res_pos, res_src;
  logic             row_set_full;

  assign in_stall  = (state_r != hsm_pkg::S_IDLE);
  assign in_fire   = in_valid && (state_r == hsm_pkg::S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign exec_fire = (state_r == hsm_pkg::S_EXEC) && out_free;

  assign hin_row      = RIW'(hin_r >> BW);
  assign hin_bit      = hin_r[BW-1:0];
  assign hin_in_range = ({1'b0, hin_r} < (HW + 1)'(NUM_HANDLES));
  assign cur_row      = (cmd_r == hsm_pkg::CMD_ADD) ? add_row_r : hin_row;
  assign cnt_pos      = HW'(count_r);

  // lowest row that still has a free handle
  always_comb begin
    free_row = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (!row_full_r[r]) begin
        free_row = RIW'(r);
      end
    end
  end

  // row contents: never-written rows read as all free; handles past the
  // table end count as occupied
  always_comb begin
    for (int b = 0; b < ROW_W; b++) begin
      row_mask[b] = ((int'(cur_row) * ROW_W + b) < NUM_HANDLES);
    end
    live_eff = row_valid_r[cur_row] ? live_rd : '0;
    occ      = live_eff | ~row_mask;
  end

  // first free bit in the selected row
  always_comb begin
    fz       = '0;
    fz_found = 1'b0;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (!occ[b]) begin
        fz       = BW'(b);
        fz_found = 1'b1;
      end
    end
  end

  assign h_new    = HW'({add_row_r, fz});
  assign hin_live = hin_in_range && live_eff[hin_bit];

  // read side: addresses only matter in the read cycle
  assign rd_en        = (state_r == hsm_pkg::S_READ);
  assign live_rd_addr = (cmd_r == hsm_pkg::CMD_ADD) ? free_row : hin_row;
  assign hnd_rd_addr  = (count_r == '0) ? '0 : HW'(count_r - CW'(1));

  // execute: result and write-back values
  always_comb begin
    res_status   = hsm_pkg::ST_BAD;
    res_handle   = hin_r;
    res_pos      = '0;
    res_src      = '0;
    count_nxt    = count_r;
    live_wr_en   = 1'b0;
    live_wr_data = live_eff;
    pos_wr_en    = 1'b0;
    pos_wr_addr  = h_new;
    pos_wr_data  = cnt_pos;
    hnd_wr_en    = 1'b0;
    hnd_wr_addr  = cnt_pos;
    hnd_wr_data  = h_new;
    row_set_full = 1'b0;
    unique case (cmd_r)
      hsm_pkg::CMD_ADD: begin
        if ((count_r >= CW'(NUM_HANDLES)) || !fz_found) begin
          res_status = hsm_pkg::ST_FULL;
          res_handle = '0;
        end else begin
          res_status   = hsm_pkg::ST_OK;
          res_handle   = h_new;
          res_pos      = cnt_pos;
          count_nxt    = count_r + CW'(1);
          live_wr_en   = 1'b1;
          live_wr_data = live_eff | (ROW_W'(1) << fz);
          pos_wr_en    = 1'b1;
          hnd_wr_en    = 1'b1;
          row_set_full = &(live_wr_data | ~row_mask);
        end
      end
      hsm_pkg::CMD_DEL: begin
        if (hin_live) begin
          // last-position owner takes over the freed position
          res_status   = hsm_pkg::ST_OK;
          res_pos      = pos_rd;
          res_src      = hnd_rd_addr;
          count_nxt    = count_r - CW'(1);
          live_wr_en   = 1'b1;
          live_wr_data = live_eff & ~(ROW_W'(1) << hin_bit);
          pos_wr_en    = 1'b1;
          pos_wr_addr  = hnd_rd;
          pos_wr_data  = pos_rd;
          hnd_wr_en    = 1'b1;
          hnd_wr_addr  = pos_rd;
          hnd_wr_data  = hnd_rd;
        end
      end
      hsm_pkg::CMD_MOD: begin
        if (hin_live) begin
          res_status = hsm_pkg::ST_OK;
          res_pos    = pos_rd;
        end
      end
      default: begin
        res_status = hsm_pkg::ST_BAD;
      end
    endcase
  end

  assign live_wr_addr = cur_row;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hsm_pkg::S_IDLE: if (in_fire) state_nxt = hsm_pkg::S_READ;
      hsm_pkg::S_READ: state_nxt = hsm_pkg::S_EXEC;
      hsm_pkg::S_EXEC: if (out_free) state_nxt = hsm_pkg::S_IDLE;
      default:         state_nxt = hsm_pkg::S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hsm_pkg::S_IDLE;
      count_r     <= '0;
      row_valid_r <= '0;
      row_full_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
        if (live_wr_en) begin
          row_valid_r[cur_row] <= 1'b1;
          row_full_r[cur_row]  <= row_set_full;
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_cmd;
      hin_r <= in_handle_in;
    end
    if (state_r == hsm_pkg::S_READ) begin
      add_row_r <= free_row;
    end
    if (exec_fire) begin
      out_status_r <= res_status;
      out_handle_r <= res_handle;
      out_pos_r    <= res_pos;
      out_src_r    <= res_src;
    end
  end

  // live bitmap, one row per word
  hsm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS),
    .AW    (RIW)
  ) u_live_ram (
    .clk     (clk),
    .wr_en   (exec_fire && live_wr_en),
    .wr_addr (live_wr_addr),
    .wr_data (live_wr_data),
    .rd_en   (rd_en),
    .rd_addr (live_rd_addr),
    .rd_data (live_rd)
  );

  // handle -> dense position
  hsm_ram #(
    .WIDTH (HW),
    .DEPTH (NUM_HANDLES),
    .AW    (HW)
  ) u_pos_ram (
    .clk     (clk),
    .wr_en   (exec_fire && pos_wr_en),
    .wr_addr (pos_wr_addr),
    .wr_data (pos_wr_data),
    .rd_en   (rd_en),
    .rd_addr (hin_r),
    .rd_data (pos_rd)
  );

  // dense position -> handle (inverse map, finds the last entry's owner)
  hsm_ram #(
    .WIDTH (HW),
    .DEPTH (NUM_HANDLES),
    .AW    (HW)
  ) u_hnd_ram (
    .clk     (clk),
    .wr_en   (exec_fire && hnd_wr_en),
    .wr_addr (hnd_wr_addr),
    .wr_data (hnd_wr_data),
    .rd_en   (rd_en),
    .rd_addr (hnd_rd_addr),
    .rd_data (hnd_rd)
  );

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_handle_out  = out_handle_r;
  assign out_position    = out_pos_r;
  assign out_move_source = out_src_r;
  assign out_live_count  = count_r;

`include "assert_macros.svh"

  `ASSERT_PROP(a_count_max, clk, rst_n, count_r <= CW'(NUM_HANDLES), "live count past table size")
  `ASSERT_NEXT(a_del_dec, clk, rst_n, exec_fire && (cmd_r == hsm_pkg::CMD_DEL) && (res_status == hsm_pkg::ST_OK), count_r == $past(count_r) - CW'(1), "delete did not drop count")
  `ASSERT_PROP(a_full_rows, clk, rst_n, (count_r == CW'(NUM_HANDLES)) |-> (&row_full_r), "full table with free row")
  `ASSERT_NEXT(a_one_beat, clk, rst_n, exec_fire, state_r == hsm_pkg::S_IDLE, "execute not followed by idle")

endmodule
